// ===== rtl/core/gts_pkg.sv =====
// ----------------------------------------------------------------------------
// gts_pkg: shared types and constants of the geometric-mean threshold scorer
// Command and status structs between controller and datapath, field widths.
// ----------------------------------------------------------------------------
package gts_pkg;

   localparam int ChanW   = 16;
   localparam int LogW    = 22;   // signed log2 in units of 2^-16, -16..0
   localparam int SumW    = 42;   // signed weighted sum
   localparam int CntW    = 17;
   localparam int FitW    = 17;
   localparam int HalfQ16 = 32768;

   // configuration register indexes
   typedef enum logic [1:0] {
      REG_WEIGHTS_LO = 2'd0,
      REG_WEIGHTS_HI = 2'd1,
      REG_THRESHOLD  = 2'd2
   } csr_reg_type;

   typedef struct packed {
      logic load;       // latch the input item
      logic log_start;  // start log2 of the selected operand
      logic log_thr;    // operand is threshold instead of a channel
      logic acc;        // accumulate product of the finished log
      logic decide;     // form the decision and count it
      logic div_start;  // start the two rate divisions
      logic finish;     // write the result register
   } cmd_type;

   typedef struct packed {
      logic log_done;
      logic div_done;
   } sts_type;

endpackage

// ===== rtl/core/gts_ctrl.sv =====
// ----------------------------------------------------------------------------
// gts_ctrl: sequencer of the scorer
// Steps one channel at a time through the shared log2 unit, then the
// threshold log, decision and, on the last item, the rate divisions.
// ----------------------------------------------------------------------------
module gts_ctrl #(
   parameter int CHANNELS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             last,
   input  logic             out_free,
   input  gts_pkg::sts_type sts,
   output gts_pkg::cmd_type cmd,
   output logic             busy
);
   localparam int IdxW = (CHANNELS > 1) ? $clog2(CHANNELS + 1) : 1;

   typedef enum logic [2:0] {
      S_IDLE, S_LOG, S_THR, S_DEC, S_DIV, S_OUT
   } state_type;

   state_type       state_ff, state_in;
   logic [IdxW-1:0] idx_ff, idx_in;
   logic            wait_ff, wait_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      wait_in  = wait_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               idx_in   = '0;
               wait_in  = 1'b0;
               state_in = S_LOG;
            end
         end
         S_LOG: begin
            if (!wait_ff) begin
               cmd.log_start = 1'b1;
               wait_in       = 1'b1;
            end else if (sts.log_done) begin
               cmd.acc = 1'b1;
               wait_in = 1'b0;
               idx_in  = idx_ff + 1'b1;
               if (idx_ff == IdxW'(CHANNELS - 1)) state_in = S_THR;
            end
         end
         S_THR: begin
            cmd.log_thr = 1'b1;
            if (!wait_ff) begin
               cmd.log_start = 1'b1;
               wait_in       = 1'b1;
            end else if (sts.log_done) begin
               wait_in  = 1'b0;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            cmd.decide = 1'b1;
            state_in   = last ? S_DIV : S_OUT;
            if (last) cmd.div_start = 1'b1;
         end
         S_DIV: begin
            if (sts.div_done) state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         wait_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         wait_ff  <= wait_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

`ifndef ASSERT_OFF
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> state_ff == S_IDLE)
      else $error("load outside idle");
   a_acc_once: assert property (@(posedge clock) disable iff (reset)
      cmd.acc |=> !cmd.acc)
      else $error("double accumulate");
   a_div_last: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> last)
      else $error("division without last item");
`endif
endmodule

// ===== rtl/core/gts_dp.sv =====
// ----------------------------------------------------------------------------
// gts_dp: datapath of the scorer
// Shared iterative log2, weighted accumulation, decision, confusion counters
// and a bit-serial divider pair for the two class rates.
// ----------------------------------------------------------------------------
module gts_dp #(
   parameter int CHANNELS    = 8,
   parameter int MAX_SAMPLES = 65536
) (
   input  logic                          clock,
   input  logic                          reset,
   input  gts_pkg::cmd_type              cmd,
   output gts_pkg::sts_type              sts,
   input  logic [CHANNELS*gts_pkg::ChanW-1:0] chan_in,
   input  logic                          label_in,
   input  logic                          last_in,
   input  logic [127:0]                  weights,
   input  logic [15:0]                   threshold,
   output logic                          last_q,
   output logic                          abstain_q,
   output logic [gts_pkg::FitW-1:0]      fitness_q
);
   localparam int CW  = gts_pkg::CntW;
   localparam logic [CW-1:0] CapV =
      (MAX_SAMPLES < 131071) ? CW'(MAX_SAMPLES) : CW'(131071);
   localparam int SelW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic [CHANNELS*16-1:0] ch_ff;
   logic                   label_ff, last_ff;
   logic [SelW-1:0]        sel_ff;

   // latch item
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ch_ff    <= chan_in;
         label_ff <= label_in;
         last_ff  <= last_in;
      end
      if (cmd.load) sel_ff <= '0;
      else if (cmd.acc) sel_ff <= sel_ff + 1'b1;
   end
   assign last_q = last_ff;

   // log2 unit: leading-one normalise at start, then 16 squaring steps
   logic [15:0] op;
   logic [15:0] opc;
   logic [3:0]  lz_p;
   logic [16:0] m_ff;
   logic [15:0] frac_ff;
   logic [4:0]  p_ff, step_ff;
   logic        lrun_ff;
   logic [33:0] sq;

   assign op  = cmd.log_thr ? threshold : ch_ff[sel_ff*16 +: 16];
   assign opc = (op == 16'd0) ? 16'd1 : op;

   always_comb begin
      lz_p = 4'd0;
      for (int i = 0; i < 16; i++) if (opc[i]) lz_p = 4'(i);
   end

   assign sq = {17'd0, m_ff} * {17'd0, m_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         lrun_ff <= 1'b0;
      end else if (cmd.log_start) begin
         lrun_ff <= 1'b1;
         step_ff <= '0;
         frac_ff <= '0;
         p_ff    <= {1'b0, lz_p};
         m_ff    <= {1'b0, opc << (4'd15 - lz_p)};
      end else if (lrun_ff) begin
         if (sq[32:15] >= 18'd65536) begin
            m_ff    <= sq[32:16];
            frac_ff <= {frac_ff[14:0], 1'b1};
         end else begin
            m_ff    <= sq[31:15];
            frac_ff <= {frac_ff[14:0], 1'b0};
         end
         step_ff <= step_ff + 1'b1;
         if (step_ff == 5'd15) lrun_ff <= 1'b0;
      end
   end

   logic done_ff;
   always_ff @(posedge clock) begin
      if (reset) done_ff <= 1'b0;
      else done_ff <= lrun_ff && step_ff == 5'd15;
   end
   assign sts.log_done = done_ff;

   logic signed [gts_pkg::LogW-1:0] logv;
   assign logv = $signed({{(gts_pkg::LogW-21){1'b0}}, p_ff, 16'd0})
               - $signed(gts_pkg::LogW'(32'd1048576)) + $signed({6'd0, frac_ff});

   // weighted accumulation
   logic signed [gts_pkg::SumW-1:0] lsum_ff;
   logic [19:0] wsum_ff;
   logic [15:0] w_sel;
   assign w_sel = weights[sel_ff*16 +: 16];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         lsum_ff <= '0;
         wsum_ff <= '0;
      end else if (cmd.acc) begin
         lsum_ff <= lsum_ff
                  + gts_pkg::SumW'(logv) * gts_pkg::SumW'($signed({1'b0, w_sel}));
         wsum_ff <= wsum_ff + 20'(w_sel);
      end
   end

   // decision; threshold product formed once log is done
   logic signed [gts_pkg::SumW-1:0] tsum_ff;
   always_ff @(posedge clock) begin
      if (done_ff && cmd.log_thr)
         tsum_ff <= gts_pkg::SumW'(logv) * gts_pkg::SumW'($signed({1'b0, wsum_ff}));
   end

   logic dec;
   always_comb begin
      if (wsum_ff == '0) dec = threshold < 16'(gts_pkg::HalfQ16);
      else if (threshold == '0) dec = 1'b1;
      else dec = lsum_ff > tsum_ff;
   end

   // confusion counters
   logic [CW-1:0] tp_ff, fn_ff, tn_ff, fp_ff;
   logic [CW-1:0] tp_n, fn_n, tn_n, fp_n;
   function automatic logic [CW-1:0] bump(input logic [CW-1:0] c, input logic en);
      return (en && c < CapV) ? c + 1'b1 : (c > CapV ? CapV : c);
   endfunction
   assign tp_n = bump(tp_ff, label_ff && dec);
   assign fn_n = bump(fn_ff, label_ff && !dec);
   assign fp_n = bump(fp_ff, !label_ff && dec);
   assign tn_n = bump(tn_ff, !label_ff && !dec);

   always_ff @(posedge clock) begin
      if (reset) begin
         tp_ff <= '0; fn_ff <= '0; tn_ff <= '0; fp_ff <= '0;
      end else if (cmd.decide) begin
         if (last_ff) begin
            tp_ff <= '0; fn_ff <= '0; tn_ff <= '0; fp_ff <= '0;
         end else begin
            tp_ff <= tp_n; fn_ff <= fn_n; tn_ff <= tn_n; fp_ff <= fp_n;
         end
      end
   end

   // restoring dividers, one quotient bit per cycle for both rates
   localparam int DW = CW + 1;
   logic [CW+16-1:0] na_ff, nb_ff;
   logic [DW-1:0]    da_ff, db_ff, ra_ff, rb_ff;
   logic [16:0]      qa_ff, qb_ff;
   logic [5:0]       dcnt_ff;
   logic             drun_ff, ddone_ff;
   logic [DW-1:0]    ra_s, rb_s;
   assign ra_s = {ra_ff[DW-2:0], na_ff[CW+15]};
   assign rb_s = {rb_ff[DW-2:0], nb_ff[CW+15]};

   always_ff @(posedge clock) begin
      if (reset) begin
         drun_ff  <= 1'b0;
         ddone_ff <= 1'b0;
      end else begin
         ddone_ff <= 1'b0;
         if (cmd.decide) abstain_q <= dec;
         if (cmd.div_start) begin
            drun_ff <= 1'b1;
            dcnt_ff <= '0;
            na_ff   <= {tp_n, 16'd0};
            nb_ff   <= {tn_n, 16'd0};
            da_ff   <= DW'(tp_n) + DW'(fn_n);
            db_ff   <= DW'(tn_n) + DW'(fp_n);
            ra_ff   <= '0; rb_ff <= '0; qa_ff <= '0; qb_ff <= '0;
         end else if (drun_ff) begin
            na_ff <= na_ff << 1;
            nb_ff <= nb_ff << 1;
            if (ra_s >= da_ff) begin
               ra_ff <= ra_s - da_ff; qa_ff <= {qa_ff[15:0], 1'b1};
            end else begin
               ra_ff <= ra_s; qa_ff <= {qa_ff[15:0], 1'b0};
            end
            if (rb_s >= db_ff) begin
               rb_ff <= rb_s - db_ff; qb_ff <= {qb_ff[15:0], 1'b1};
            end else begin
               rb_ff <= rb_s; qb_ff <= {qb_ff[15:0], 1'b0};
            end
            dcnt_ff <= dcnt_ff + 1'b1;
            if (dcnt_ff == 6'(CW + 15)) begin
               drun_ff  <= 1'b0;
               ddone_ff <= 1'b1;
            end
         end
      end
   end
   assign sts.div_done = ddone_ff;

   // rate of an empty class is zero
   logic [17:0] fsum;
   assign fsum = ((da_ff == '0) ? 18'd0 : {1'b0, qa_ff})
               + ((db_ff == '0) ? 18'd0 : {1'b0, qb_ff});
   always_ff @(posedge clock) begin
      if (cmd.decide) fitness_q <= '0;
      else if (ddone_ff) fitness_q <= fsum[17:1];
   end

`ifndef ASSERT_OFF
   a_log_len: assert property (@(posedge clock) disable iff (reset)
      cmd.log_start |-> !lrun_ff)
      else $error("log2 restarted while running");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !drun_ff)
      else $error("divider restarted while running");
   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      tp_ff <= CapV && fn_ff <= CapV && tn_ff <= CapV && fp_ff <= CapV)
      else $error("counter beyond cap");
`endif
endmodule

// ===== rtl/core/geomean_threshold_scorer_unit.sv =====
// ----------------------------------------------------------------------------
// geomean_threshold_scorer_unit: weighted geometric-mean abstain scorer
// Channel  | dir | handshake
// req      | in  | req_tvalid/req_tready, tdata channels, tuser label, tlast
// rsp      | out | rsp_tvalid/rsp_tready, tdata fitness, tuser abstain, tlast
// csr      | in  | csr_we, index, data (no wait)
// Flow: the shared log2 unit takes one channel at a time, then the
// threshold log and the decision; a last item also runs the rate dividers.
// Reset clears counters and control; registers return to reset values.
// The result register frees the input once its item is taken.
// ----------------------------------------------------------------------------
module geomean_threshold_scorer_unit #(
   parameter int CHANNELS    = 8,
   parameter int MAX_SAMPLES = 65536
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // channel_0 .. channel_7
   input  logic [7:0]   req_tuser,   // label_abstain, zero
   input  logic         req_tlast,   // last_sample
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [23:0]  rsp_tdata,   // fitness, zero
   output logic [7:0]   rsp_tuser,   // abstain, zero
   output logic         rsp_tlast,   // set_done
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [63:0]  csr_data
);
   logic [63:0] wlo_ff, whi_ff;
   logic [15:0] thr_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wlo_ff <= '1;
         whi_ff <= '1;
         thr_ff <= 16'd32768;
      end else if (csr_we) begin
         unique case (csr_index)
            gts_pkg::REG_WEIGHTS_LO: wlo_ff <= csr_data;
            gts_pkg::REG_WEIGHTS_HI: whi_ff <= csr_data;
            gts_pkg::REG_THRESHOLD:  thr_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   gts_pkg::cmd_type cmd;
   gts_pkg::sts_type sts;
   logic busy, last_q, abstain_q;
   logic [16:0] fitness_q;
   logic valid_ff;

   assign req_tready = !busy;

   gts_ctrl #(.CHANNELS(CHANNELS)) u_ctrl (
      .clock, .reset,
      .start(req_tvalid),
      .last(last_q),
      .out_free(!valid_ff || rsp_tready),
      .sts, .cmd, .busy
   );

   gts_dp #(.CHANNELS(CHANNELS), .MAX_SAMPLES(MAX_SAMPLES)) u_dp (
      .clock, .reset, .cmd, .sts,
      .chan_in(req_tdata[CHANNELS*16-1:0]),
      .label_in(req_tuser[0]),
      .last_in(req_tlast),
      .weights({whi_ff, wlo_ff}),
      .threshold(thr_ff),
      .last_q, .abstain_q, .fitness_q
   );

   // result register
   logic        ab_ff, ld_ff;
   logic [16:0] fit_ff;
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (cmd.finish) valid_ff <= 1'b1;
      else if (rsp_tready) valid_ff <= 1'b0;
      if (cmd.finish) begin
         ab_ff  <= abstain_q;
         ld_ff  <= last_q;
         fit_ff <= last_q ? fitness_q : 17'd0;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {7'd0, fit_ff};
   assign rsp_tuser  = {7'd0, ab_ff};
   assign rsp_tlast  = ld_ff;

`ifndef ASSERT_OFF
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped under stall");
   a_fit0: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata == 24'd0)
      else $error("fitness outside set end");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("accepted twice");
`endif
endmodule
